/* hdl/cfss_pkg.sv */
`default_nettype none
package cfss_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam int unsigned MAX_TEXT_DEF    = 16384;
  localparam int unsigned POS_W           = 14;

  // UTF-8 byte values used by the lower-case fold
  localparam logic [7:0] ASCII_TOP    = 8'h80;
  localparam logic [7:0] ASCII_UP_LO  = 8'h41;
  localparam logic [7:0] ASCII_UP_HI  = 8'h5A;
  localparam logic [7:0] CYR_LEAD_D0  = 8'hD0;
  localparam logic [7:0] CYR_LEAD_D1  = 8'hD1;
  localparam logic [7:0] CYR_A_LO     = 8'h90;
  localparam logic [7:0] CYR_A_HI     = 8'h9F;
  localparam logic [7:0] CYR_R_LO     = 8'hA0;
  localparam logic [7:0] CYR_R_HI     = 8'hAF;
  localparam logic [7:0] CYR_YO_UP    = 8'h81;
  localparam logic [7:0] CYR_YO_LOW   = 8'h91;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PATTERN = 2'd1,
    FUNC_TEXT    = 2'd2
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] char_code;
    logic        last;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;
  } out_t;

  function automatic logic [31:0] fold_code(input logic [31:0] code);
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = code[7:0];
    b1 = code[15:8];
    if (b0 < ASCII_TOP) begin
      if (b0 >= ASCII_UP_LO && b0 <= ASCII_UP_HI) begin
        b0 = b0 + CASE_OFFSET;
      end
    end else if (b0 == CYR_LEAD_D0) begin
      if (b1 >= CYR_A_LO && b1 <= CYR_A_HI) begin
        b1 = b1 + CASE_OFFSET;
      end else if (b1 >= CYR_R_LO && b1 <= CYR_R_HI) begin
        b0 = CYR_LEAD_D1;
        b1 = b1 - CASE_OFFSET;
      end else if (b1 == CYR_YO_UP) begin
        b0 = CYR_LEAD_D1;
        b1 = CYR_YO_LOW;
      end
    end
    return {code[31:16], b1, b0};
  endfunction

endpackage
`default_nettype wire

/* hdl/case_folding_substring_search_top.sv */
`default_nettype none
// Streaming substring search. Load the pattern with append words (func 1), then
// send text words (func 2); on the text word flagged last one result word comes
// out with found, the start index of the first match and an overflow flag, and
// the text state clears while the pattern is kept. A clear word (func 0) drops
// both. Each character is one four-byte UTF-8 code; with fold_case set, ASCII
// and basic Cyrillic capitals compare equal to their lower-case forms. One word
// is taken every cycle: the text window and the pattern register are compared
// in parallel in the cycle the word is accepted, and the result lands in an
// output register backed by one skid entry, so input stalls only while both are
// full. An empty pattern reports found at index 0; characters beyond
// MAX_PATTERN or MAX_TEXT are dropped and set overflow.
module case_folding_substring_search_top
  import cfss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int unsigned MAX_TEXT    = MAX_TEXT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic cfg_data_i
);

  localparam int unsigned PlenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CntW  = $clog2(MAX_TEXT + 1);
  localparam int unsigned CmpW  = (CntW > PlenW) ? CntW : PlenW;

  logic                fold_q;
  logic [31:0]         pat_q [MAX_PATTERN];
  logic [31:0]         win_q [MAX_PATTERN];
  logic [31:0]         win_d [MAX_PATTERN];
  logic [31:0]         win_new [MAX_PATTERN];
  logic [PlenW-1:0]    plen_q, plen_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                seen_q, seen_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic                ovf_q, ovf_d;
  logic                pat_shift;
  logic [MAX_PATTERN-1:0] eq;
  logic                win_match;
  logic                in_acc;
  logic                res_valid;
  out_t                res_data;
  logic                out_valid_q, skid_valid_q;
  out_t                out_q, skid_q;
  logic                out_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fold_q <= cfg_data_i;
    end
  end

  // Window after this word would be shifted in; newest character at entry 0.
  always_comb begin
    win_new[0] = in_data_i.char_code;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  // Pattern register holds the newest pattern character at entry 0 too, so
  // window entry k lines up with pattern entry k for every k below the length.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
    logic [31:0] w_c, p_c;
    assign w_c = fold_q ? fold_code(win_new[k]) : win_new[k];
    assign p_c = fold_q ? fold_code(pat_q[k]) : pat_q[k];
    assign eq[k] = (w_c == p_c) || (32'(plen_q) <= k);
  end
  assign win_match = &eq;

  always_comb begin
    plen_d    = plen_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    pat_shift = 1'b0;
    res_valid = 1'b0;
    res_data  = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k];
    end
    if (in_acc) begin
      case (in_data_i.func)
        FUNC_CLEAR: begin
          plen_d = '0;
          cnt_d  = '0;
          seen_d = 1'b0;
          idx_d  = '0;
          ovf_d  = 1'b0;
          for (int k = 0; k < MAX_PATTERN; k++) begin
            win_d[k] = '0;
          end
        end
        FUNC_PATTERN: begin
          if (32'(plen_q) < MAX_PATTERN) begin
            pat_shift = 1'b1;
            plen_d    = plen_q + PlenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        FUNC_TEXT: begin
          if (32'(cnt_q) < MAX_TEXT) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
              win_d[k] = win_new[k];
            end
            cnt_d = cnt_q + CntW'(1);
            if (!seen_q && plen_q != '0 && CmpW'(cnt_d) >= CmpW'(plen_q) && win_match) begin
              seen_d = 1'b1;
              idx_d  = CntW'(CmpW'(cnt_d) - CmpW'(plen_q));
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            res_valid         = 1'b1;
            res_data.found    = (plen_q == '0) ? 1'b1 : seen_d;
            res_data.position = (plen_q != '0 && seen_d) ? POS_W'(idx_d) : '0;
            res_data.overflow = ovf_d;
            // drop the text state, keep the pattern
            cnt_d  = '0;
            seen_d = 1'b0;
            idx_d  = '0;
            ovf_d  = 1'b0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
              win_d[k] = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      idx_q  <= '0;
      ovf_q  <= 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      plen_q <= plen_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      idx_q  <= idx_d;
      ovf_q  <= ovf_d;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_shift) begin
      pat_q[0] <= in_data_i.char_code;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        pat_q[k] <= pat_q[k-1];
      end
    end
  end

  // Output register plus one skid entry; a new result goes to the skid only
  // when the output register is full and held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res_data;
      end else begin
        skid_q <= res_data;
      end
    end
  end

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  a_plen_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(plen_q) <= MAX_PATTERN)
    else $error("pattern length beyond limit");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_TEXT)
    else $error("text count beyond limit");

  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (cnt_q == '0 && !seen_q && !ovf_q))
    else $error("text state not cleared after result");

  // the pattern may grow after a match is latched, so only the start is bounded
  a_match_needs_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (plen_q != '0 && idx_q < cnt_q))
    else $error("latched match inconsistent with pattern and text count");

endmodule
`default_nettype wire
